FILE: hdl/acd_pkg.sv
// Shared types, tag codes and helpers for the AVI chunk demultiplexer.
`timescale 1ns / 1ps
`default_nettype none

package acd_pkg;

   // Result queue between parser and output
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // Chunk tags as they sit in the window, first byte in the top lane
   localparam logic [31:0] TAG_AUDIO = 32'h3031_7762;   // "01wb"
   localparam logic [31:0] TAG_VIDEO = 32'h3030_6463;   // "00dc"
   localparam logic [31:0] TAG_INDEX = 32'h6964_7831;   // "idx1"

   // Register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_ENABLE = 2'd2;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_SIZE,
      PH_PAYLOAD,
      PH_PAD
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_AUDIO,
      KIND_VIDEO,
      KIND_INDEX
   } kind_type;

   typedef struct packed {
      logic block_enable;
      logic audio_out_enable;
      logic video_out_enable;
   } cfg_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       stream_kind;
      logic       first_of_chunk;
      logic       last_of_chunk;
   } beat_type;

   function automatic kind_type tag_kind(input logic [31:0] w);
      kind_type k;
      k = KIND_NONE;
      if (w == TAG_AUDIO) k = KIND_AUDIO;
      else if (w == TAG_VIDEO) k = KIND_VIDEO;
      else if (w == TAG_INDEX) k = KIND_INDEX;
      return k;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/acd_parser.sv
// Front end: hunts for chunk tags, reads chunk sizes and classifies payload bytes.
`timescale 1ns / 1ps
`default_nettype none

module acd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire acd_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   input  wire logic [7:0]        in_byte,
   output logic                   out_valid,
   output acd_pkg::beat_type      out_beat
);

   logic [31:0]         window_ff, window_in;
   logic                sync_ff, sync_in;
   acd_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]          hcnt_ff, hcnt_in;
   acd_pkg::kind_type   kind_ff, kind_in;
   logic [31:0]         size_ff, size_in;
   logic [31:0]         rem_ff, rem_in;
   logic                pad_ff, pad_in;

   logic [31:0]         shifted;
   logic [31:0]         size_full;
   acd_pkg::kind_type   found;
   logic                emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         sync_ff   <= 1'b0;
         phase_ff  <= acd_pkg::PH_TAG;
         hcnt_ff   <= '0;
         kind_ff   <= acd_pkg::KIND_NONE;
         size_ff   <= '0;
         rem_ff    <= '0;
         pad_ff    <= 1'b0;
      end else begin
         window_ff <= window_in;
         sync_ff   <= sync_in;
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         kind_ff   <= kind_in;
         size_ff   <= size_in;
         rem_ff    <= rem_in;
         pad_ff    <= pad_in;
      end
   end

   always_comb begin
      window_in = window_ff;
      sync_in   = sync_ff;
      phase_in  = phase_ff;
      hcnt_in   = hcnt_ff;
      kind_in   = kind_ff;
      size_in   = size_ff;
      rem_in    = rem_ff;
      pad_in    = pad_ff;
      emit      = 1'b0;

      shifted = {window_ff[23:0], in_byte};
      found   = acd_pkg::tag_kind(shifted);

      // size is little endian: place the byte by its header position
      unique case (hcnt_ff)
         2'd0: size_full = size_ff | {24'd0, in_byte};
         2'd1: size_full = size_ff | {16'd0, in_byte, 8'd0};
         2'd2: size_full = size_ff | {8'd0, in_byte, 16'd0};
         default: size_full = size_ff | {in_byte, 24'd0};
      endcase

      if (in_valid && cfg.block_enable) begin
         if (!sync_ff) begin
            window_in = shifted;
            if (found != acd_pkg::KIND_NONE) begin
               sync_in  = 1'b1;
               kind_in  = found;
               phase_in = acd_pkg::PH_SIZE;
               hcnt_in  = '0;
               size_in  = '0;
            end
         end else begin
            unique case (phase_ff)
               acd_pkg::PH_TAG: begin
                  window_in = shifted;
                  hcnt_in   = hcnt_ff + 2'd1;
                  if (hcnt_ff == 2'd3) begin
                     if (found == acd_pkg::KIND_NONE) begin
                        // unknown tag: fall back to hunting from this window
                        sync_in = 1'b0;
                        kind_in = acd_pkg::KIND_NONE;
                     end else begin
                        kind_in  = found;
                        phase_in = acd_pkg::PH_SIZE;
                        size_in  = '0;
                     end
                  end
               end
               acd_pkg::PH_SIZE: begin
                  size_in = size_full;
                  hcnt_in = hcnt_ff + 2'd1;
                  if (hcnt_ff == 2'd3) begin
                     pad_in   = size_full[0];
                     rem_in   = size_full;
                     phase_in = (size_full == 32'd0) ? acd_pkg::PH_TAG : acd_pkg::PH_PAYLOAD;
                  end
               end
               acd_pkg::PH_PAYLOAD: begin
                  emit = (kind_ff == acd_pkg::KIND_AUDIO && cfg.audio_out_enable) ||
                         (kind_ff == acd_pkg::KIND_VIDEO && cfg.video_out_enable);
                  rem_in = rem_ff - 32'd1;
                  if (rem_ff == 32'd1)
                     phase_in = pad_ff ? acd_pkg::PH_PAD : acd_pkg::PH_TAG;
               end
               default: begin
                  pad_in   = 1'b0;
                  phase_in = acd_pkg::PH_TAG;
                  hcnt_in  = '0;
               end
            endcase
         end
      end
   end

   assign out_valid               = emit;
   assign out_beat.payload_byte   = in_byte;
   assign out_beat.stream_kind    = (kind_ff == acd_pkg::KIND_VIDEO);
   assign out_beat.first_of_chunk = (rem_ff == size_ff);
   assign out_beat.last_of_chunk  = (rem_ff == 32'd1);

endmodule

`default_nettype wire

FILE: hdl/acd_queue.sv
// Back end: small result queue that hands beats to the consumer.
`timescale 1ns / 1ps
`default_nettype none

module acd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire acd_pkg::beat_type  wr_beat,
   input  wire logic               rd_en,
   output acd_pkg::beat_type       rd_beat,
   output logic                    full,
   output logic                    empty
);

   acd_pkg::beat_type                 slot_ff [acd_pkg::QDEPTH];
   logic [acd_pkg::QPTR_W-1:0]        wptr_ff, wptr_in;
   logic [acd_pkg::QPTR_W-1:0]        rptr_ff, rptr_in;
   logic [acd_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_wr, do_rd;

   assign full  = (count_ff == acd_pkg::QCNT_W'(acd_pkg::QDEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_comb begin
      wptr_in  = do_wr ? wptr_ff + acd_pkg::QPTR_W'(1) : wptr_ff;
      rptr_in  = do_rd ? rptr_ff + acd_pkg::QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd)
         count_in = count_ff + acd_pkg::QCNT_W'(1);
      else if (do_rd && !do_wr)
         count_in = count_ff - acd_pkg::QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr)
         slot_ff[wptr_ff] <= wr_beat;
   end

   assign rd_beat = slot_ff[rptr_ff];

endmodule

`default_nettype wire

FILE: hdl/avi_chunk_demux_unit.sv
// Top level of the AVI chunk demultiplexer: registers, parser and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Takes an AVI byte stream one byte per clock while req_full is low and returns
// the payload bytes of audio (01wb) and video (00dc) chunks, each marked with
// its kind and with first/last flags; index chunks, pad bytes and headers yield
// nothing. The parser handles each byte in the cycle it is pushed, so the input
// runs at one byte per cycle unless the queue is full. Results wait in a
// 4-entry queue, read from its head on the rsp_ ports; full rises only once
// four beats are waiting unpopped. After an unknown tag the block drops sync and
// hunts again from the last four bytes. Write the registers only while idle.
module avi_chunk_demux_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [7:0]                     req_stream_byte,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [7:0]                          rsp_payload_byte,
   output logic                                rsp_stream_kind,
   output logic                                rsp_first_of_chunk,
   output logic                                rsp_last_of_chunk,
   input  wire logic                           csr_we,
   input  wire logic [acd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [0:0]                     csr_wdata
);

   acd_pkg::cfg_type   cfg_ff, cfg_in;
   logic               accept;
   logic               beat_valid;
   acd_pkg::beat_type  beat;
   acd_pkg::beat_type  head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            acd_pkg::CSR_BLOCK_ENABLE: cfg_in.block_enable     = csr_wdata[0];
            acd_pkg::CSR_AUDIO_ENABLE: cfg_in.audio_out_enable = csr_wdata[0];
            acd_pkg::CSR_VIDEO_ENABLE: cfg_in.video_out_enable = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cfg_ff <= '0;
      else
         cfg_ff <= cfg_in;
   end

   assign accept = req_push && !req_full;

   acd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (accept),
      .in_byte   (req_stream_byte),
      .out_valid (beat_valid),
      .out_beat  (beat)
   );

   acd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (beat_valid),
      .wr_beat (beat),
      .rd_en   (rsp_pop),
      .rd_beat (head),
      .full    (req_full),
      .empty   (rsp_empty)
   );

   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_stream_kind    = head.stream_kind;
   assign rsp_first_of_chunk = head.first_of_chunk;
   assign rsp_last_of_chunk  = head.last_of_chunk;

   // a beat only comes from an accepted byte
   a_beat_from_accept: assert property (@(posedge clock) disable iff (reset)
      beat_valid |-> accept)
      else $error("result beat without an accepted byte");

   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      !cfg_ff.block_enable |-> !beat_valid)
      else $error("result beat while block disabled");

   a_kind_enabled: assert property (@(posedge clock) disable iff (reset)
      beat_valid |-> (beat.stream_kind ? cfg_ff.video_out_enable
                                       : cfg_ff.audio_out_enable))
      else $error("result beat for a disabled output");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("queue not empty after reset");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the AVI chunk demultiplexer.
`timescale 1ns / 1ps

module tb;
   import acd_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [7:0]           req_stream_byte = 8'h00;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [7:0]           rsp_payload_byte;
   logic                 rsp_stream_kind;
   logic                 rsp_first_of_chunk;
   logic                 rsp_last_of_chunk;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BLOCK_ENABLE;
   logic [0:0]           csr_wdata = 1'b0;

   avi_chunk_demux_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_stream_byte    (req_stream_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_stream_kind    (rsp_stream_kind),
      .rsp_first_of_chunk (rsp_first_of_chunk),
      .rsp_last_of_chunk  (rsp_last_of_chunk),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // bytes waiting to be pushed, the planned stream, and the payload beats we expect back
   logic [7:0]  byte_queue[$];
   logic [7:0]  stream_plan[$];
   beat_type    payload_beats[$];

   // demux state as the block should hold it
   cfg_type     cfg = '0;
   logic [31:0] window = '0;
   logic        synced = 1'b0;
   phase_type   parse_ph = PH_TAG;
   logic [1:0]  hdr_cnt = '0;
   kind_type    chunk = KIND_NONE;
   logic [31:0] size_acc = '0;
   logic [31:0] remaining = '0;
   logic        pad_due = 1'b0;

   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   bit          send_steady = 1'b0;
   bit          recv_steady = 1'b0;
   int unsigned errors = 0;
   int unsigned beats_seen = 0;
   int unsigned stall_cycles = 0;

   wire byte_taken = req_push && !req_full;
   wire beat_taken = rsp_pop && !rsp_empty;

   function automatic kind_type classify_tag(input logic [31:0] w);
      if (w == TAG_AUDIO) return KIND_AUDIO;
      if (w == TAG_VIDEO) return KIND_VIDEO;
      if (w == TAG_INDEX) return KIND_INDEX;
      return KIND_NONE;
   endfunction

   // mostly short gaps, a few long ones, none at all during a steady stretch
   function automatic int unsigned pick_gap(input bit steady);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic start_size(input kind_type k);
      chunk = k;
      parse_ph = PH_SIZE;
      hdr_cnt = '0;
      size_acc = '0;
   endtask

   task automatic demux_byte(input logic [7:0] b);
      kind_type k;
      logic     emit;
      if (!cfg.block_enable) return;
      if (!synced) begin
         window = {window[23:0], b};
         k = classify_tag(window);
         if (k != KIND_NONE) begin
            synced = 1'b1;
            start_size(k);
         end
         return;
      end
      case (parse_ph)
         PH_TAG: begin
            window = {window[23:0], b};
            hdr_cnt = hdr_cnt + 2'd1;
            if (hdr_cnt == 2'd0) begin
               k = classify_tag(window);
               if (k == KIND_NONE) begin
                  // unknown tag: back to hunting, window kept
                  synced = 1'b0;
                  chunk = KIND_NONE;
               end else begin
                  start_size(k);
               end
            end
         end
         PH_SIZE: begin
            size_acc |= 32'(b) << (8 * hdr_cnt);
            hdr_cnt = hdr_cnt + 2'd1;
            if (hdr_cnt == 2'd0) begin
               pad_due = size_acc[0];
               remaining = size_acc;
               parse_ph = (size_acc == 0) ? PH_TAG : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            emit = (chunk == KIND_AUDIO && cfg.audio_out_enable) ||
                   (chunk == KIND_VIDEO && cfg.video_out_enable);
            if (emit)
               payload_beats.push_back({b, chunk == KIND_VIDEO, remaining == size_acc,
                                        remaining == 32'd1});
            remaining = remaining - 32'd1;
            if (remaining == 0) parse_ph = pad_due ? PH_PAD : PH_TAG;
         end
         default: begin
            pad_due = 1'b0;
            parse_ph = PH_TAG;
            hdr_cnt = '0;
         end
      endcase
   endtask

   // input side: one beat in flight, held while full
   always @(posedge clock) begin : drive_req
      logic       hold;
      logic       next_push;
      logic [7:0] next_byte;
      hold = req_push && req_full;
      next_push = hold;
      next_byte = req_stream_byte;
      if (reset) begin
         next_push = 1'b0;
      end else begin
         if (byte_taken) demux_byte(req_stream_byte);
         if (!hold) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (byte_queue.size() != 0) begin
               next_push = 1'b1;
               next_byte = byte_queue.pop_front();
               if ($urandom_range(0, 99) < 2) send_steady = !send_steady;
               send_gap = pick_gap(send_steady);
            end
         end
      end
      req_push <= next_push;
      req_stream_byte <= next_byte;
   end

   // result side: compare each popped beat with the oldest expected one
   always @(posedge clock) begin : check_rsp
      beat_type got;
      beat_type want;
      logic     next_pop;
      next_pop = 1'b0;
      if (!reset) begin
         if (beat_taken) begin
            got = {rsp_payload_byte, rsp_stream_kind, rsp_first_of_chunk, rsp_last_of_chunk};
            if (payload_beats.size() == 0) begin
               note_error($sformatf("unexpected beat byte %02h kind %0b first %0b last %0b",
                                    got.payload_byte, got.stream_kind,
                                    got.first_of_chunk, got.last_of_chunk));
            end else begin
               want = payload_beats.pop_front();
               if (got != want)
                  note_error($sformatf({"beat %0d (exp/got): byte %02h/%02h kind %0b/%0b ",
                                        "first %0b/%0b last %0b/%0b"}, beats_seen,
                                       want.payload_byte, got.payload_byte,
                                       want.stream_kind, got.stream_kind,
                                       want.first_of_chunk, got.first_of_chunk,
                                       want.last_of_chunk, got.last_of_chunk));
            end
            beats_seen++;
            if ($urandom_range(0, 99) < 2) recv_steady = !recv_steady;
            recv_gap = pick_gap(recv_steady);
         end
         if (recv_gap != 0) recv_gap--;
         else next_pop = 1'b1;
      end
      rsp_pop <= next_pop;
   end

   always @(posedge clock) begin
      if (reset || byte_taken || beat_taken) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("avi_chunk_demux_unit: mismatch");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
   endtask

   task automatic apply_config(input cfg_type c);
      write_reg(CSR_BLOCK_ENABLE, c.block_enable);
      write_reg(CSR_AUDIO_ENABLE, c.audio_out_enable);
      write_reg(CSR_VIDEO_ENABLE, c.video_out_enable);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = c;
   endtask

   // drained: nothing left to send or to receive, plus a settling wait for a byte that yields no beat
   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_push || payload_beats.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // mostly well-formed chunks with random payloads, some junk and cut-off tags
   task automatic build_plan(input int unsigned target);
      int unsigned r;
      int unsigned n;
      int unsigned i;
      logic [31:0] tag;
      while (stream_plan.size() < target) begin
         r = $urandom_range(0, 99);
         if (r < 83) begin
            tag = (r < 40) ? TAG_AUDIO : (r < 75) ? TAG_VIDEO : TAG_INDEX;
            r = $urandom_range(0, 99);
            n = (r < 10) ? 0 : (r < 20) ? 1 : (r < 88) ? $urandom_range(2, 24) :
                (r < 97) ? $urandom_range(25, 80) : $urandom_range(250, 300);
            for (i = 0; i < 4; i++) stream_plan.push_back(tag[31 - 8 * i -: 8]);
            for (i = 0; i < 4; i++) stream_plan.push_back(n[8 * i +: 8]);
            for (i = 0; i < n; i++) stream_plan.push_back(8'($urandom));
            if (n[0]) stream_plan.push_back(8'($urandom));
         end else if (r < 93) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) stream_plan.push_back(8'($urandom));
         end else begin
            tag = (r < 96) ? TAG_AUDIO : TAG_VIDEO;
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) stream_plan.push_back(tag[31 - 8 * i -: 8]);
         end
      end
   endtask

   initial begin : stimulus
      cfg_type     sweep[6];
      cfg_type     setting;
      logic [7:0]  opening[$];
      int unsigned n;
      int unsigned phase_no;
      // video size 2 with extreme bytes, audio size 1 with pad, empty index, unknown tag
      opening = '{8'h30, 8'h30, 8'h64, 8'h63, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'h30, 8'h31, 8'h77, 8'h62, 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A, 8'hA5,
                  8'h69, 8'h64, 8'h78, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h52, 8'h49, 8'h46, 8'h46};
      sweep = '{3'b000, 3'b101, 3'b110, 3'b100, 3'b011, 3'b111};
      build_plan(1450);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      apply_config(3'b111);
      @(negedge clock);
      byte_queue = opening;
      wait_idle();

      // phase boundaries fall mid-chunk, so enables also gate chunks part way through
      phase_no = 0;
      while (stream_plan.size() != 0) begin
         if (phase_no < 6) begin
            setting = sweep[phase_no];
         end else begin
            setting.block_enable = ($urandom_range(0, 99) < 85);
            setting.audio_out_enable = $urandom_range(0, 1);
            setting.video_out_enable = $urandom_range(0, 1);
         end
         apply_config(setting);
         @(negedge clock);
         if (!setting.block_enable) begin
            n = $urandom_range(20, 60);
            repeat (n) byte_queue.push_back(8'($urandom));
         end else begin
            n = $urandom_range(60, 200);
            while (n != 0 && stream_plan.size() != 0) begin
               byte_queue.push_back(stream_plan.pop_front());
               n--;
            end
         end
         wait_idle();
         phase_no++;
      end

      repeat (16) @(negedge clock);
      if (errors == 0 && payload_beats.size() == 0) begin
         $display("avi_chunk_demux_unit: match");
      end else begin
         $display("avi_chunk_demux_unit: mismatch");
      end
      $finish;
   end

endmodule
